// ===== hw/rtl/bht_pkg.sv =====
// ----------------------------------------------------------------------------
// bht_pkg
// Shared types and codes for the bucketised key-value table.
// ----------------------------------------------------------------------------
`default_nettype none

package bht_pkg;

  localparam int KEY_W   = 64;
  localparam int VAL_W   = 64;
  localparam int REQ_W   = 2;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 10;
  localparam int MASK_W  = 8;

  // request codes
  localparam logic [REQ_W-1:0] REQ_GET    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_PUT    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_MISS = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

  localparam logic [MASK_W-1:0] MASK_RESET = 8'hFF;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } bht_in_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [VAL_W-1:0]   result_value;
    logic [COUNT_W-1:0] entry_count;
  } bht_out_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bht_bucket_map.sv =====
// ----------------------------------------------------------------------------
// bht_bucket_map
// Key and mask to bucket index, reduced modulo the number of built buckets.
// ----------------------------------------------------------------------------
`default_nettype none

module bht_bucket_map #(
  parameter int BUCKET_COUNT = 256
) (
  input  wire logic [bht_pkg::MASK_W-1:0]                         mask,
  input  wire logic [bht_pkg::MASK_W-1:0]                         key_lo,
  output logic      [(BUCKET_COUNT > 1 ? $clog2(BUCKET_COUNT) : 1)-1:0] bucket
);

  localparam int BIDX_W  = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
  localparam int TAB_LEN = 1 << bht_pkg::MASK_W;

  logic [BIDX_W-1:0]          mod_tab [TAB_LEN];
  logic [bht_pkg::MASK_W-1:0] masked;

  // constant table: i mod BUCKET_COUNT
  for (genvar i = 0; i < TAB_LEN; i++) begin : g_tab
    assign mod_tab[i] = BIDX_W'(i % BUCKET_COUNT);
  end

  assign masked = key_lo & mask;
  assign bucket = mod_tab[masked];

endmodule

`default_nettype wire

// ===== hw/rtl/bht_kv_mem.sv =====
// ----------------------------------------------------------------------------
// bht_kv_mem
// Slot key and value storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bht_kv_mem #(
  parameter int DEPTH = 768
) (
  input  wire logic                                   clk,
  input  wire logic                                   rd_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [bht_pkg::KEY_W-1:0]              rd_key,
  output logic      [bht_pkg::VAL_W-1:0]              rd_val,
  input  wire logic                                   wr_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [bht_pkg::KEY_W-1:0]              wr_key,
  input  wire logic [bht_pkg::VAL_W-1:0]              wr_val
);

  logic [bht_pkg::KEY_W-1:0] key_mem [DEPTH];
  logic [bht_pkg::VAL_W-1:0] val_mem [DEPTH];
  logic [bht_pkg::KEY_W-1:0] rd_key_r;
  logic [bht_pkg::VAL_W-1:0] rd_val_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr] <= wr_key;
      val_mem[wr_addr] <= wr_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_key_r <= key_mem[rd_addr];
      rd_val_r <= val_mem[rd_addr];
    end
  end

  assign rd_key = rd_key_r;
  assign rd_val = rd_val_r;

endmodule

`default_nettype wire

// ===== hw/rtl/bucketized_hash_table_top.sv =====
// ----------------------------------------------------------------------------
// bucketized_hash_table_top
// Key-value table with fixed slots per bucket: get, put and remove requests.
// ----------------------------------------------------------------------------
// Timing: for each slot read the sequencer steps S_RD then S_CMP, up to SLOTS_PER_BUCKET
//   slots, stopping at the first hit; then S_ACT, and out_valid strobes from a register set there.
// Requests: one transaction at a time, busy until the sequencer is back in S_IDLE;
//   the single key/value read port and the one key comparator set this.
// Reset (rst_n low, synchronous): sequencer, entry count and mask (to 255) reset,
//   then a clearing pass over every bucket zeroes the valid marks, busy high.
//   Results cannot be stalled.
`default_nettype none

module bucketized_hash_table_top #(
  parameter int BUCKET_COUNT     = 256,
  parameter int SLOTS_PER_BUCKET = 3
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // request channel
  input  wire logic                       start,
  output logic                            busy,
  input  wire bht_pkg::bht_in_t           in_data,
  // result channel
  output logic                            out_valid,
  output bht_pkg::bht_out_t               out_data,
  // configuration
  input  wire logic                       cfg_we,
  input  wire logic [bht_pkg::MASK_W-1:0] cfg_wdata
);

  localparam int DEPTH     = BUCKET_COUNT * SLOTS_PER_BUCKET;
  localparam int BIDX_W    = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
  localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SLOT_W    = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int OUT_CNT_W = bht_pkg::COUNT_W;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS_PER_BUCKET - 1);
  localparam logic [BIDX_W-1:0] LAST_BKT  = BIDX_W'(BUCKET_COUNT - 1);

  // one-hot sequencer
  typedef enum logic [4:0] {
    S_CLR  = 5'b00001,  // clearing pass after reset
    S_IDLE = 5'b00010,  // wait for a request
    S_RD   = 5'b00100,  // issue slot read
    S_CMP  = 5'b01000,  // compare returned key
    S_ACT  = 5'b10000   // update table, emit result
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [bht_pkg::MASK_W-1:0] mask_r;

  // latched request
  logic [bht_pkg::REQ_W-1:0] req_r;
  logic [bht_pkg::KEY_W-1:0] key_r;
  logic [bht_pkg::VAL_W-1:0] val_r;
  logic [BIDX_W-1:0]         bkt_r;
  logic [ADDR_W-1:0]         base_r;

  // scan state
  logic [SLOT_W-1:0]         slot_r;
  logic                      hit_r;
  logic [SLOT_W-1:0]         hit_slot_r;
  logic [bht_pkg::VAL_W-1:0] hit_val_r;

  // valid marks, one row per bucket, read into row_r at accept
  logic [SLOTS_PER_BUCKET-1:0] vld_mem [BUCKET_COUNT];
  logic [SLOTS_PER_BUCKET-1:0] row_r;
  logic [BIDX_W-1:0]           clr_idx_r;
  logic [CNT_W-1:0]            cnt_r;

  // result register
  logic              out_valid_r;
  bht_pkg::bht_out_t out_r;

  logic [BIDX_W-1:0]           bkt_in;
  logic [SLOTS_PER_BUCKET-1:0] cur_row;
  logic [SLOT_W-1:0]           free_slot;
  logic                        free_any;
  logic                        match;
  logic [ADDR_W-1:0]           rd_addr;
  logic [bht_pkg::KEY_W-1:0]   rd_key;
  logic [bht_pkg::VAL_W-1:0]   rd_val;
  logic                        rd_en;
  logic                        wr_en;
  logic [ADDR_W-1:0]           wr_addr;
  logic                        do_put;
  logic                        do_remove;
  logic                        accept;
  logic                        vld_we;
  logic [BIDX_W-1:0]           vld_waddr;
  logic [SLOTS_PER_BUCKET-1:0] vld_wdata;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  bht_bucket_map #(
    .BUCKET_COUNT (BUCKET_COUNT)
  ) u_map (
    .mask   (mask_r),
    .key_lo (in_data.key[bht_pkg::MASK_W-1:0]),
    .bucket (bkt_in)
  );

  assign rd_en   = (state_r == S_RD);
  assign rd_addr = base_r + ADDR_W'(slot_r);

  bht_kv_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_key  (rd_key),
    .rd_val  (rd_val),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_key  (key_r),
    .wr_val  (val_r)
  );

  assign cur_row = row_r;
  assign match   = cur_row[slot_r] && (rd_key == key_r);

  // lowest free slot of the selected bucket
  always_comb begin
    free_slot = '0;
    for (int i = SLOTS_PER_BUCKET - 1; i >= 0; i--) begin
      if (!cur_row[i]) free_slot = SLOT_W'(i);
    end
    free_any = ~&cur_row;
  end

  // decisions taken in the action state
  assign do_put    = (state_r == S_ACT) && (req_r == bht_pkg::REQ_PUT) && !hit_r && free_any;
  assign do_remove = (state_r == S_ACT) && (req_r == bht_pkg::REQ_REMOVE) && hit_r;
  assign wr_en     = do_put;
  assign wr_addr   = base_r + ADDR_W'(free_slot);

  // valid row write-back: zero rows while clearing, updated row on a change
  always_comb begin
    vld_wdata = row_r;
    if (do_put) vld_wdata[free_slot] = 1'b1;
    if (do_remove) vld_wdata[hit_slot_r] = 1'b0;
    if (state_r == S_CLR) vld_wdata = '0;
  end

  assign vld_we    = (state_r == S_CLR) || do_put || do_remove;
  assign vld_waddr = (state_r == S_CLR) ? clr_idx_r : bkt_r;

  always_ff @(posedge clk) begin
    if (vld_we) begin
      vld_mem[vld_waddr] <= vld_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      row_r <= vld_mem[bkt_in];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r <= '0;
    end else if (state_r == S_CLR) begin
      clr_idx_r <= clr_idx_r + BIDX_W'(1);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLR: begin
        if (clr_idx_r == LAST_BKT) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) state_nxt = S_RD;
      end
      S_RD: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (match || (slot_r == LAST_SLOT)) state_nxt = S_ACT;
        else state_nxt = S_RD;
      end
      S_ACT: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= bht_pkg::MASK_RESET;
    end else if (cfg_we) begin
      mask_r <= cfg_wdata;
    end
  end

  // request capture and scan bookkeeping
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r  <= in_data.req_type;
      key_r  <= in_data.key;
      val_r  <= in_data.value;
      bkt_r  <= bkt_in;
      base_r <= ADDR_W'(bkt_in * SLOTS_PER_BUCKET);
    end
    if (state_r == S_CMP && !match && slot_r != LAST_SLOT) begin
      slot_r <= slot_r + SLOT_W'(1);
    end else if (accept) begin
      slot_r <= '0;
    end
    if (state_r == S_CMP && match) begin
      hit_slot_r <= slot_r;
      hit_val_r  <= rd_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (accept) begin
      hit_r <= 1'b0;
    end else if (state_r == S_CMP && match) begin
      hit_r <= 1'b1;
    end
  end

  // entry count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (do_put) begin
      cnt_r <= cnt_r + CNT_W'(1);
    end else if (do_remove) begin
      if (cnt_r != '0) cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  // result transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == S_ACT);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_ACT) begin
      out_r.status       <= bht_pkg::STAT_MISS;
      out_r.result_value <= '0;
      case (req_r)
        bht_pkg::REQ_GET: begin
          if (hit_r) begin
            out_r.status       <= bht_pkg::STAT_OK;
            out_r.result_value <= hit_val_r;
          end
        end
        bht_pkg::REQ_PUT: begin
          if (!hit_r) out_r.status <= free_any ? bht_pkg::STAT_OK : bht_pkg::STAT_FULL;
        end
        bht_pkg::REQ_REMOVE: begin
          if (hit_r) begin
            out_r.status       <= bht_pkg::STAT_OK;
            out_r.result_value <= hit_val_r;
          end
        end
        default: begin
          out_r.status <= bht_pkg::STAT_MISS;
        end
      endcase
      // count after this request's update
      if (do_put) begin
        out_r.entry_count <= OUT_CNT_W'(cnt_r + CNT_W'(1));
      end else if (do_remove && cnt_r != '0) begin
        out_r.entry_count <= OUT_CNT_W'(cnt_r - CNT_W'(1));
      end else begin
        out_r.entry_count <= OUT_CNT_W'(cnt_r);
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire
